// ===== rtl/fmcp_pkg.sv =====
// Shared types and constants for the framed motor command parser.
// Depends on nothing; the parser module imports it.
package fmcp_pkg;

  // Start marker value after reset.
  localparam logic [7:0] StartMarkerReset = 8'hBB;

  // Frame parser phase.
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_MARK = 3'd1,
    PH_ID   = 3'd2,
    PH_HIGH = 3'd3,
    PH_LOW  = 3'd4
  } phase_t;

  // One completed frame as it leaves the parser.
  typedef struct packed {
    logic [7:0]  received_sum;
    logic [7:0]  computed_sum;
    logic [15:0] speed_value;
    logic [7:0]  device_id;
  } frame_data_t;

endpackage

// ===== rtl/framed_motor_command_parser.sv =====
// A frame's result appears on out_tvalid in the cycle after its checksum byte is transferred.
// Throughput: one byte per cycle; the only stall is a result that waits in the output register.
// The phase register changes only on a byte transfer; the output register also clears when its result is taken.
// Reset (rst_n low, synchronous): parser hunts for a start byte, marker returns to 0xBB,
// held bytes clear and no result is pending.
// Depends on fmcp_pkg for the phase type, the result struct and the marker reset value.
module framed_motor_command_parser (
  input  logic        clk,
  input  logic        rst_n,
  // Marker register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,      // start_marker
  // Received byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // rx_byte
  // Completed frames.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // device_id[7:0], speed_value[23:8],
                                     // computed_sum[31:24], received_sum[39:32]
  output logic        out_tuser      // checksum_ok
);

  import fmcp_pkg::*;

  logic [7:0]  marker_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_id_r, held_id_nxt;
  logic [7:0]  held_high_r, held_high_nxt;
  logic [7:0]  held_low_r, held_low_nxt;
  logic        out_valid_r, out_valid_nxt;
  frame_data_t out_data_r, out_data_nxt;
  logic        out_ok_r, out_ok_nxt;

  logic        in_fire;
  logic        is_mark;
  logic        emit;
  logic [7:0]  sum;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= StartMarkerReset;
    end else if (cfg_valid) begin
      marker_r <= cfg_data;
    end
  end

  // A new byte is taken whenever the output register is free or drains this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_mark   = (in_tdata == marker_r);
  assign sum       = held_id_r ^ held_high_r ^ held_low_r;

  // Next phase and captured bytes.
  always_comb begin
    phase_nxt     = phase_r;
    held_id_nxt   = held_id_r;
    held_high_nxt = held_high_r;
    held_low_nxt  = held_low_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (is_mark) phase_nxt = PH_MARK;
        end
        PH_MARK: begin
          if (is_mark) begin
            phase_nxt = PH_MARK;
          end else begin
            held_id_nxt = in_tdata;
            phase_nxt   = PH_ID;
          end
        end
        PH_ID: begin
          if (is_mark) begin
            phase_nxt = PH_MARK;
          end else begin
            held_high_nxt = in_tdata;
            phase_nxt     = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (is_mark) begin
            phase_nxt = PH_MARK;
          end else begin
            held_low_nxt = in_tdata;
            phase_nxt    = PH_LOW;
          end
        end
        PH_LOW: begin
          phase_nxt = is_mark ? PH_MARK : PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Result generation on the checksum byte.
  always_comb begin
    emit                      = in_fire && (phase_r == PH_LOW) && !is_mark;
    out_valid_nxt             = out_valid_r;
    out_data_nxt              = out_data_r;
    out_ok_nxt                = out_ok_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (emit) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.device_id    = held_id_r;
      out_data_nxt.speed_value  = {held_high_r, held_low_r};
      out_data_nxt.computed_sum = sum;
      out_data_nxt.received_sum = in_tdata;
      out_ok_nxt                = (sum == in_tdata);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      out_valid_r <= 1'b0;
      held_id_r   <= 8'd0;
      held_high_r <= 8'd0;
      held_low_r  <= 8'd0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      held_id_r   <= held_id_nxt;
      held_high_r <= held_high_nxt;
      held_low_r  <= held_low_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

`ifndef NO_ASSERTIONS
  // A result appears only after a non-marker byte was taken in the checksum phase.
  a_rise_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_fire && (phase_r == PH_LOW) && !is_mark))
    else $error("result appeared without a completed frame");

  // The checksum flag agrees with the two sums carried with it.
  a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_data_r.computed_sum == out_data_r.received_sum)))
    else $error("checksum flag disagrees with sums");

  // A completed frame sends the parser back to hunting.
  a_back_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (phase_r == PH_HUNT))
    else $error("parser did not return to hunting after a frame");

  // No byte is taken while an unaccepted result holds the output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("byte taken while result register is blocked");
`endif

endmodule

// ===== sim/tb_framed_motor_command_parser.sv =====
// Self-checking testbench for framed_motor_command_parser: directed frames, resync cases and
// random frame traffic under several idle and stall patterns, checked against a local parser.
// Depends on fmcp_pkg and the parser RTL only.
module tb_framed_motor_command_parser;
  import fmcp_pkg::*;

  localparam int CycleLimit = 300000;

  // One expected frame with its checksum flag.
  typedef struct {
    frame_data_t fields;
    logic        sum_ok;
  } frame_expect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;          // device_id, speed_value, computed_sum, received_sum
  logic        out_tuser;          // checksum_ok

  // Local copy of the parser state and the marker register.
  logic [7:0]    cur_marker = StartMarkerReset;
  phase_t        frame_phase = PH_HUNT;
  logic [7:0]    held_id = 8'h00;
  logic [7:0]    held_high = 8'h00;
  logic [7:0]    held_low = 8'h00;
  frame_expect_t pending_frames[$];

  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int rx_stall_pct = 0;

  framed_motor_command_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %h, want %h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // Advance the local parser by one accepted byte and queue any completed frame.
  function automatic void parse_rx_byte(logic [7:0] rx);
    frame_expect_t frame;
    logic [7:0]    sum;
    if (frame_phase == PH_HUNT) begin
      if (rx == cur_marker) frame_phase = PH_MARK;
    end else if (rx == cur_marker) begin
      frame_phase = PH_MARK;
    end else begin
      case (frame_phase)
        PH_MARK: begin
          held_id = rx;
          frame_phase = PH_ID;
        end
        PH_ID: begin
          held_high = rx;
          frame_phase = PH_HIGH;
        end
        PH_HIGH: begin
          held_low = rx;
          frame_phase = PH_LOW;
        end
        PH_LOW: begin
          sum = held_id ^ held_high ^ held_low;
          frame.fields.device_id = held_id;
          frame.fields.speed_value = {held_high, held_low};
          frame.fields.computed_sum = sum;
          frame.fields.received_sum = rx;
          frame.sum_ok = (sum == rx);
          pending_frames.push_back(frame);
          frame_phase = PH_HUNT;
        end
        default: frame_phase = PH_HUNT;
      endcase
    end
  endfunction

  // Compare each result transfer with the oldest expected frame.
  always @(posedge clk) begin : check_frames
    frame_data_t   got;
    frame_expect_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected frame id", 16'(got.device_id), 16'h0);
      end else begin
        want = pending_frames.pop_front();
        if (got.device_id !== want.fields.device_id)
          report_mismatch("device_id", 16'(got.device_id), 16'(want.fields.device_id));
        if (got.speed_value !== want.fields.speed_value)
          report_mismatch("speed_value", got.speed_value, want.fields.speed_value);
        if (got.computed_sum !== want.fields.computed_sum)
          report_mismatch("computed_sum", 16'(got.computed_sum),
                          16'(want.fields.computed_sum));
        if (got.received_sum !== want.fields.received_sum)
          report_mismatch("received_sum", 16'(got.received_sum),
                          16'(want.fields.received_sum));
        if (out_tuser !== want.sum_ok)
          report_mismatch("checksum_ok", 16'(out_tuser), 16'(want.sum_ok));
      end
    end
  end

  // Send one byte, with an optional random gap first, and predict on its transfer.
  task automatic send_byte(logic [7:0] rx);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_rx_byte(rx);
  endtask

  task automatic send_frame(logic [7:0] id, logic [7:0] high, logic [7:0] low,
                            logic [7:0] sum);
    send_byte(cur_marker);
    send_byte(id);
    send_byte(high);
    send_byte(low);
    send_byte(sum);
  endtask

  // Change the marker once the stream is quiet and every frame has come out.
  task automatic write_marker(logic [7:0] value);
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_marker = value;
  endtask

  // Mostly a byte that is not the marker, now and then any byte.
  function automatic logic [7:0] pick_data();
    logic [7:0] value;
    value = 8'($urandom_range(255));
    while (value == cur_marker && $urandom_range(9) != 0) value = 8'($urandom_range(255));
    return value;
  endfunction

  // Field extremes and a bad checksum.
  task automatic test_frame_fields();
    send_frame(8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'h00);
  endtask

  // Noise while hunting, restarts in the speed high byte and checksum positions.
  task automatic test_resync();
    send_byte(8'h12);
    send_byte(cur_marker);
    send_byte(8'h01);
    send_byte(cur_marker);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h04);
    send_byte(cur_marker);
    send_frame(8'h05, 8'h06, 8'h07, 8'h04);
  endtask

  // Random frames, broken frames and noise under one marker and one idle pattern.
  task automatic run_random_phase(logic [7:0] marker, int send_pct, int stall_pct,
                                  int n_items);
    int         sent;
    int         kind;
    int         extra;
    logic [7:0] id;
    logic [7:0] high;
    logic [7:0] low;
    logic [7:0] sum;
    write_marker(marker);
    send_idle_pct = send_pct;
    rx_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        id = pick_data();
        high = pick_data();
        low = pick_data();
        sum = ($urandom_range(99) < 65) ? (id ^ high ^ low) : pick_data();
        send_frame(id, high, low, sum);
        sent += 5;
      end else if (kind < 90) begin
        extra = $urandom_range(3);
        send_byte(cur_marker);
        repeat (extra) send_byte(8'($urandom_range(255)));
        sent += 1 + extra;
      end else begin
        send_byte(8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  task automatic test_no_idling();
    run_random_phase(8'h00, 0, 0, 200);
  endtask

  task automatic test_sender_gaps();
    run_random_phase(8'hFF, 70, 0, 200);
  endtask

  task automatic test_receiver_stalls();
    run_random_phase(8'($urandom_range(255)), 0, 70, 200);
  endtask

  task automatic test_mixed_idling();
    run_random_phase(StartMarkerReset, 27, 27, 200);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_frame_fields();
    test_resync();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fmcp_pkg.sv
rtl/framed_motor_command_parser.sv
sim/tb_framed_motor_command_parser.sv
